/* hw/rtl/acc_exec_pkg.sv */
// ----------------------------------------------------------------------------
// acc_exec_pkg
// Types and codes shared by the accumulator machine execute step and its
// iterative divider.
// ----------------------------------------------------------------------------
package acc_exec_pkg;

    localparam int ADDR_W    = 8;
    localparam int ADDR_SPAN = 2 ** ADDR_W;
    localparam int TARGET_W  = 10;
    localparam int WORD_W    = 32;
    localparam int DIV_STEPS = WORD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        CMD_LOAD_DATA = 2'd0,
        CMD_EXECUTE   = 2'd1,
        CMD_RESTART   = 2'd2
    } cmd_e;

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MULT    = 4'd2,
        OP_DIV     = 4'd3,
        OP_LOAD    = 4'd4,
        OP_STORE   = 4'd5,
        OP_BRANY   = 4'd6,
        OP_BRPOS   = 4'd7,
        OP_BRZERO  = 4'd8,
        OP_BRNEG   = 4'd9,
        OP_SYSCALL = 4'd10
    } op_e;

    typedef enum logic [1:0] {
        RUN_READY    = 2'd0,
        RUN_BLOCKED  = 2'd1,
        RUN_FINISHED = 2'd2
    } run_state_e;

    localparam logic [1:0] SYSCALL_HALT = 2'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_RESULT
    } exec_state_e;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_FIX
    } div_state_e;

    typedef struct packed {
        logic [1:0]                 cmd;
        logic [3:0]                 opcode;
        logic                       immediate_mode;
        logic signed [WORD_W-1:0]   immediate_value;
        logic [ADDR_W-1:0]          data_address;
        logic [TARGET_W-1:0]        branch_target;
        logic [1:0]                 syscall_number;
        logic signed [WORD_W-1:0]   data_value;
    } item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]   acc_out;
        logic [TARGET_W-1:0]        pc_out;
        logic [1:0]                 run_state;
        logic                       branch_taken;
        logic                       divide_error;
    } result_t;

    typedef struct packed {
        logic                       start;
        logic                       signed_mode;
    } div_ctl_t;

endpackage

/* hw/rtl/acc_exec_div.sv */
// ----------------------------------------------------------------------------
// acc_exec_div
// Iterative 32-bit restoring divider, one quotient bit per cycle, with
// optional two's complement sign handling (quotient truncates toward zero).
// ----------------------------------------------------------------------------
module acc_exec_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  acc_exec_pkg::div_ctl_t           ctl,
    input  logic [acc_exec_pkg::WORD_W-1:0]  dividend,
    input  logic [acc_exec_pkg::WORD_W-1:0]  divisor,
    output logic                             done,
    output logic [acc_exec_pkg::WORD_W-1:0]  quotient,
    output logic [acc_exec_pkg::WORD_W-1:0]  remainder
);
    import acc_exec_pkg::*;

    div_state_e            state_reg, state_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0]     rem_reg, rem_next;
    logic [WORD_W-1:0]     quo_reg, quo_next;
    logic [WORD_W-1:0]     dvs_reg, dvs_next;
    logic                  neg_reg, neg_next;
    logic [WORD_W:0]       shifted;
    logic [WORD_W:0]       diff;

    assign shifted = {rem_reg, quo_reg[WORD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        neg_next   = neg_reg;
        case (state_reg)
            DV_IDLE:
            begin
                if (ctl.start)
                begin
                    neg_next = ctl.signed_mode && (dividend[WORD_W-1] ^ divisor[WORD_W-1]);
                    quo_next = (ctl.signed_mode && dividend[WORD_W-1]) ? (~dividend + 1'b1)
                                                                       : dividend;
                    dvs_next = (ctl.signed_mode && divisor[WORD_W-1]) ? (~divisor + 1'b1)
                                                                      : divisor;
                    rem_next   = '0;
                    cnt_next   = DIV_CNT_W'(DIV_STEPS - 1);
                    state_next = DV_RUN;
                end
            end
            DV_RUN:
            begin
                if (shifted >= {1'b0, dvs_reg})
                begin
                    rem_next = diff[WORD_W-1:0];
                    quo_next = {quo_reg[WORD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[WORD_W-1:0];
                    quo_next = {quo_reg[WORD_W-2:0], 1'b0};
                end
                if (cnt_reg == '0)
                    state_next = DV_FIX;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            DV_FIX:
            begin
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= DV_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done      = (state_reg == DV_FIX);
    assign quotient  = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign remainder = rem_reg;

endmodule

/* hw/rtl/accumulator_cpu_execute_step.sv */
// ----------------------------------------------------------------------------
// accumulator_cpu_execute_step
// Execute step of a small accumulator machine: data word loads, context
// restart and execution of one externally fetched instruction per item.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   : item_valid / item_stall / item. One command per transfer.
//   result channel : result_valid / result_stall / result. Exactly one result
//                    per accepted item, in order.
//   The block works on one item at a time; item_stall is low only while idle.
//   States from transfer in to result valid:
//     load data word, restart, unused command   : ST_RESULT
//     execute, all opcodes but DIV              : ST_EXEC, ST_RESULT
//     DIV with nonzero divisor                  : ST_EXEC, ST_DIV, ST_RESULT
//     branch to a target at or above PROG_DEPTH : as DIV (target reduced by the
//                                                 same divider); ST_DIV: 32 steps
//   The shared iterative divider sets the worst case; a new item can transfer
//   in the cycle after the previous result is loaded into the output register.
//   A finished result waits in the output register while result_stall is
//   high; the next item is still accepted, and its result holds until the
//   register frees up.
//   Reset clears acc, pc and the run state to ready. Data memory holds no
//   reset value; read only words that were written.
// ----------------------------------------------------------------------------
module accumulator_cpu_execute_step #(
    parameter int DATA_DEPTH = 256,
    parameter int PROG_DEPTH = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  acc_exec_pkg::item_t    item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output acc_exec_pkg::result_t  result
);
    import acc_exec_pkg::*;

    localparam int AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
    localparam int PW = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;

    exec_state_e        state_reg, state_next;
    logic [WORD_W-1:0]  acc_reg, acc_next;
    logic [PW-1:0]      pc_reg, pc_next;
    run_state_e         run_reg, run_next;
    logic               taken_reg, taken_next;
    logic               derr_reg, derr_next;
    logic               mod_reg, mod_next;
    item_t              item_reg, item_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [WORD_W-1:0]  opnd_reg;
    logic               result_valid_reg;
    result_t            result_reg;

    logic [AW-1:0]      addr_tab [ADDR_SPAN];
    logic [WORD_W-1:0]  data_mem [DATA_DEPTH];

    logic               accept;
    logic               out_load;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;
    logic [AW-1:0]      idx_in;
    logic [WORD_W-1:0]  operand;
    logic [PW-1:0]      pc_plus;
    logic               acc_neg;
    logic               acc_zero;
    logic               branch;
    logic               target_ok;

    div_ctl_t           div_ctl;
    logic [WORD_W-1:0]  div_dividend;
    logic [WORD_W-1:0]  div_divisor;
    logic               div_done;
    logic [WORD_W-1:0]  div_quo;
    logic [WORD_W-1:0]  div_rem;

    for (genvar i = 0; i < ADDR_SPAN; i++)
    begin : g_addr_tab
        assign addr_tab[i] = AW'(i % DATA_DEPTH);
    end

    assign idx_in     = addr_tab[item.data_address];
    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != ST_IDLE);
    assign operand    = item_reg.immediate_mode ? item_reg.immediate_value : opnd_reg;
    assign pc_plus    = (pc_reg == PW'(PROG_DEPTH - 1)) ? '0 : pc_reg + 1'b1;
    assign acc_neg    = acc_reg[WORD_W-1];
    assign acc_zero   = (acc_reg == '0);
    assign target_ok  = (WORD_W'(item_reg.branch_target) < WORD_W'(PROG_DEPTH));

    acc_exec_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        pc_next      = pc_reg;
        run_next     = run_reg;
        taken_next   = taken_reg;
        derr_next    = derr_reg;
        mod_next     = mod_reg;
        item_next    = item_reg;
        idx_next     = idx_reg;
        mem_we       = 1'b0;
        mem_waddr    = idx_in;
        mem_wdata    = item.data_value;
        div_ctl      = '0;
        div_dividend = acc_reg;
        div_divisor  = operand;
        out_load     = 1'b0;
        branch       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    idx_next   = idx_in;
                    taken_next = 1'b0;
                    derr_next  = 1'b0;
                    state_next = ST_RESULT;
                    case (item.cmd)
                        CMD_LOAD_DATA:
                        begin
                            mem_we = 1'b1;
                        end
                        CMD_EXECUTE:
                        begin
                            state_next = ST_EXEC;
                        end
                        CMD_RESTART:
                        begin
                            acc_next = '0;
                            pc_next  = '0;
                            run_next = RUN_READY;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_EXEC:
            begin
                pc_next    = pc_plus;
                state_next = ST_RESULT;
                case (op_e'(item_reg.opcode))
                    OP_ADD:    acc_next = acc_reg + operand;
                    OP_SUB:    acc_next = acc_reg - operand;
                    OP_MULT:   acc_next = WORD_W'(acc_reg * operand);
                    OP_DIV:
                    begin
                        if (operand == '0)
                            derr_next = 1'b1;
                        else
                        begin
                            div_ctl.start       = 1'b1;
                            div_ctl.signed_mode = 1'b1;
                            mod_next            = 1'b0;
                            state_next          = ST_DIV;
                        end
                    end
                    OP_LOAD:   acc_next = operand;
                    OP_STORE:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = idx_reg;
                        mem_wdata = acc_reg;
                    end
                    OP_BRANY:  branch = 1'b1;
                    OP_BRPOS:  branch = !acc_neg && !acc_zero;
                    OP_BRZERO: branch = acc_zero;
                    OP_BRNEG:  branch = acc_neg;
                    OP_SYSCALL:
                    begin
                        run_next = (item_reg.syscall_number == SYSCALL_HALT) ? RUN_FINISHED
                                                                             : RUN_BLOCKED;
                    end
                    default:
                    begin
                    end
                endcase
                if (branch)
                begin
                    taken_next = 1'b1;
                    if (target_ok)
                        pc_next = PW'(item_reg.branch_target);
                    else
                    begin
                        div_ctl.start = 1'b1;
                        div_dividend  = WORD_W'(item_reg.branch_target);
                        div_divisor   = WORD_W'(PROG_DEPTH);
                        mod_next      = 1'b1;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (mod_reg)
                        pc_next = PW'(div_rem);
                    else
                        acc_next = div_quo;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            acc_reg          <= '0;
            pc_reg           <= '0;
            run_reg          <= RUN_READY;
            taken_reg        <= 1'b0;
            derr_reg         <= 1'b0;
            mod_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            pc_reg    <= pc_next;
            run_reg   <= run_next;
            taken_reg <= taken_next;
            derr_reg  <= derr_next;
            mod_reg   <= mod_next;
            if (out_load)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        idx_reg  <= idx_next;
        if (out_load)
        begin
            result_reg.acc_out      <= acc_reg;
            result_reg.pc_out       <= TARGET_W'(pc_reg);
            result_reg.run_state    <= run_reg;
            result_reg.branch_taken <= taken_reg;
            result_reg.divide_error <= derr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            data_mem[mem_waddr] <= mem_wdata;
        if (accept)
            opnd_reg <= data_mem[idx_in];
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide wait");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.branch_taken && result.divide_error))
        else $error("branch and divide error flagged together");

    a_pc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT) |-> (32'(pc_reg) < 32'(PROG_DEPTH)))
        else $error("program counter beyond program depth");
`endif

endmodule
